// ===== hdl/lds_pkg.sv =====
// lds_pkg: shared types and constants of the load driven frequency stepper
// holds the command and status structs between controller and datapath
// no dependencies
package lds_pkg;

    localparam int unsigned CPUS_DEF = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_UP_THR     = 3'd0;
    localparam logic [2:0] CFG_BURST_THR  = 3'd1;
    localparam logic [2:0] CFG_DOWN_THR   = 3'd2;
    localparam logic [2:0] CFG_UP_STEP    = 3'd3;
    localparam logic [2:0] CFG_DOWN_STEP  = 3'd4;
    localparam logic [2:0] CFG_DOWN_FACT  = 3'd5;
    localparam logic [2:0] CFG_PERIOD     = 3'd6;

    // reset values
    localparam logic [6:0]  RST_UP_THR    = 7'd80;
    localparam logic [6:0]  RST_BURST_THR = 7'd95;
    localparam logic [6:0]  RST_DOWN_THR  = 7'd20;
    localparam logic [6:0]  RST_UP_STEP   = 7'd5;
    localparam logic [6:0]  RST_DOWN_STEP = 7'd10;
    localparam logic [9:0]  RST_DOWN_FACT = 10'd1;
    localparam logic [31:0] RST_PERIOD    = 32'd20000;

    localparam int unsigned IN_W  = 200;
    localparam int unsigned OUT_W = 48;

    typedef enum logic [1:0] {
        BR_NONE  = 2'd0,
        BR_BURST = 2'd1,
        BR_UP    = 2'd2,
        BR_DOWN  = 2'd3
    } t_branch;

    typedef struct packed {
        logic capture;
        logic delta;
        logic mul_load;
        logic div_step;
        logic load_fin;
        logic lam_mul;
        logic lam_latch;
        logic step_mul;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic notice;
        logic cpu_ok;
        logic last;
        logic div_done;
        logic step_go;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/lds_ctrl.sv =====
// lds_ctrl: sequencing state machine of the frequency stepper
// depends on lds_pkg for the command and status structs
module lds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lds_pkg::t_status i_stat,
    output lds_pkg::t_cmd    o_cmd
);
    import lds_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DELTA    = 11'b000_0000_0010,
        S_MUL      = 11'b000_0000_0100,
        S_DIV_LOAD = 11'b000_0000_1000,
        S_LOAD_FIN = 11'b000_0001_0000,
        S_LAM_MUL  = 11'b000_0010_0000,
        S_DIV_LAM  = 11'b000_0100_0000,
        S_STEP_MUL = 11'b000_1000_0000,
        S_DIV_STEP = 11'b001_0000_0000,
        S_DECIDE   = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DELTA;
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                if (i_stat.notice) begin
                    n_state = S_IDLE;
                end else if (!i_stat.cpu_ok) begin
                    n_state = i_stat.last ? S_LAM_MUL : S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                if (i_stat.div_done) begin
                    n_state = S_LOAD_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_LOAD_FIN: begin
                o_cmd.load_fin = 1'b1;
                n_state        = i_stat.last ? S_LAM_MUL : S_IDLE;
            end
            S_LAM_MUL: begin
                o_cmd.lam_mul = 1'b1;
                n_state       = S_DIV_LAM;
            end
            S_DIV_LAM: begin
                if (i_stat.div_done) begin
                    o_cmd.lam_latch = 1'b1;
                    n_state         = i_stat.step_go ? S_STEP_MUL : S_DECIDE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_STEP_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state        = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (i_stat.div_done) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/lds_dp.sv =====
// lds_dp: datapath of the frequency stepper
// per-cpu counters, shared restoring divider, reciprocal step scaling, decision logic
// depends on lds_pkg
module lds_dp #(
    parameter int unsigned CPUS = lds_pkg::CPUS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lds_pkg::t_cmd              i_cmd,
    output lds_pkg::t_status           o_stat,
    input  logic [lds_pkg::IN_W-1:0]   i_in_data,
    input  logic                       i_in_kind,
    input  logic                       i_in_last,
    input  logic                       i_cfg_valid,
    input  logic [2:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lds_pkg::OUT_W-1:0]  o_out_data
);
    import lds_pkg::*;

    localparam int unsigned CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    // ceil(2^32/25): x/100 = ((x>>2)*RECIP_25)>>32, exact for 27-bit x>>2
    localparam logic [27:0] RECIP_25 = 28'd171798692;

    // configuration
    logic [6:0]  r_up_thr, r_burst_thr, r_down_thr, r_up_step, r_down_step;
    logic [9:0]  r_down_fact;
    logic [31:0] r_period;

    // captured item
    logic        r_kind, r_last;
    logic [1:0]  r_cpu;
    logic [31:0] r_idle, r_wall;
    logic [21:0] r_cur, r_lo, r_hi;

    // per-cpu state
    logic [31:0] r_prev_idle [CPUS];
    logic [31:0] r_prev_wall [CPUS];
    logic [6:0]  r_prev_load [CPUS];

    logic [31:0] r_di, r_dw;
    logic [6:0]  r_pload;
    logic [6:0]  r_round_max, r_ml, r_lam;
    logic        r_lam_sat;
    logic [21:0] r_target;
    logic [9:0]  r_pmult;

    // divider
    logic [38:0] r_rem;
    logic [37:0] r_dsh;
    logic [22:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_recip;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [CW-1:0] w_idx;
    logic          w_cpu_ok;
    assign w_idx    = CW'({30'd0, r_cpu});
    assign w_cpu_ok = (32'({30'd0, r_cpu}) < CPUS);

    // branch selection from the latched round maximum
    t_branch w_br;
    logic    w_edge;
    always_comb begin
        if (r_burst_thr != 7'd0 && r_ml >= r_burst_thr) begin
            w_br = BR_BURST;
        end else if (r_ml >= r_up_thr) begin
            w_br = BR_UP;
        end else if (r_ml <= r_down_thr) begin
            w_br = BR_DOWN;
        end else begin
            w_br = BR_NONE;
        end
    end
    assign w_edge = (w_br == BR_DOWN) ? (r_cur == r_lo) : (r_cur == r_hi);

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.notice   = r_kind;
    assign o_stat.cpu_ok   = w_cpu_ok;
    assign o_stat.last     = r_last;
    assign o_stat.div_done = (r_cnt == 5'd0);
    assign o_stat.step_go  = ((w_br == BR_UP) || (w_br == BR_DOWN)) && !w_edge;
    assign o_stat.out_free = w_out_free;

    // products, each registered into the divider
    logic [38:0] w_load_prod;
    logic [28:0] w_lam_prod, w_step_prod;
    logic [6:0]  w_pct;
    assign w_load_prod = {7'd0, r_dw - r_di} * 39'd100;
    assign w_lam_prod  = 29'(r_round_max) * 29'(r_cur);
    assign w_pct       = (w_br == BR_DOWN) ? r_down_step : r_up_step;
    assign w_step_prod = 29'(r_hi) * 29'(w_pct);

    // step product over 100 by reciprocal multiplication
    logic [54:0] w_recip_prod;
    assign w_recip_prod = 55'(r_rem[28:2]) * 55'(RECIP_25);

    logic        w_ge;
    assign w_ge = (r_rem >= {1'b0, r_dsh});

    // load rules
    logic [6:0] w_load, w_load_f, w_pload_new;
    logic       w_gap;
    always_comb begin
        if (r_dw == 32'd0) begin
            w_load = r_pload;
        end else if (r_dw < r_di) begin
            w_load = r_di[31] ? 7'd100 : 7'd0;
        end else begin
            w_load = r_q[6:0];
        end
        w_gap = ({1'b0, r_dw} > {r_period, 1'b0});
        if (w_gap && w_load < r_pload) begin
            w_load_f    = r_pload;
            w_pload_new = 7'd0;
        end else begin
            w_load_f    = w_load;
            w_pload_new = w_load;
        end
    end

    // step target
    logic [22:0]        w_diff;
    logic signed [24:0] w_v, w_v1;
    logic [21:0]        w_step_tgt;
    always_comb begin
        w_diff = (r_q < 23'd5) ? 23'd5 : r_q;
        if (w_br == BR_DOWN) begin
            w_v = $signed({3'd0, r_target}) - $signed({2'd0, w_diff});
        end else begin
            w_v = $signed({3'd0, r_target}) + $signed({2'd0, w_diff});
        end
        w_v1 = (w_v < $signed({3'd0, r_lo})) ? $signed({3'd0, r_lo}) : w_v;
        if (w_v1 > $signed({3'd0, r_hi})) begin
            w_v1 = $signed({3'd0, r_hi});
        end
        w_step_tgt = w_v1[21:0];
    end

    logic [21:0] w_new_tgt;
    logic [9:0]  w_new_pm;
    logic        w_set;
    always_comb begin
        w_new_tgt = r_target;
        w_new_pm  = r_pmult;
        w_set     = 1'b0;
        case (w_br)
            BR_BURST: begin
                if (r_cur < r_hi) begin
                    w_new_pm = (r_down_fact == 10'd0) ? 10'd1 : r_down_fact;
                end
                w_new_tgt = r_hi;
                w_set     = 1'b1;
            end
            BR_UP, BR_DOWN: begin
                w_new_pm = 10'd1;
                if (!w_edge) begin
                    w_new_tgt = w_step_tgt;
                    w_set     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr    <= RST_UP_THR;
            r_burst_thr <= RST_BURST_THR;
            r_down_thr  <= RST_DOWN_THR;
            r_up_step   <= RST_UP_STEP;
            r_down_step <= RST_DOWN_STEP;
            r_down_fact <= RST_DOWN_FACT;
            r_period    <= RST_PERIOD;
            r_pmult     <= 10'd1;
            r_target    <= 22'd0;
            r_round_max <= 7'd0;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CPUS; i++) begin
                r_prev_idle[i] <= 32'd0;
                r_prev_wall[i] <= 32'd0;
                r_prev_load[i] <= 7'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_UP_THR:    r_up_thr    <= i_cfg_data[6:0];
                    CFG_BURST_THR: r_burst_thr <= i_cfg_data[6:0];
                    CFG_DOWN_THR:  r_down_thr  <= i_cfg_data[6:0];
                    CFG_UP_STEP:   r_up_step   <= i_cfg_data[6:0];
                    CFG_DOWN_STEP: r_down_step <= i_cfg_data[6:0];
                    CFG_DOWN_FACT: begin
                        r_down_fact <= i_cfg_data[9:0];
                        r_pmult     <= 10'd1;
                    end
                    CFG_PERIOD:    r_period    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.delta) begin
                if (r_kind) begin
                    if (r_target < r_lo || r_target > r_hi) begin
                        r_target <= r_cur;
                    end
                end else if (w_cpu_ok) begin
                    r_prev_idle[w_idx] <= r_idle;
                    r_prev_wall[w_idx] <= r_wall;
                end
            end
            if (i_cmd.mul_load || i_cmd.lam_mul) begin
                r_cnt <= 5'd7;
            end else if (i_cmd.step_mul) begin
                r_cnt <= 5'd1;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 5'd1;
            end
            if (i_cmd.load_fin) begin
                r_prev_load[w_idx] <= w_pload_new;
                if (w_load_f > r_round_max) begin
                    r_round_max <= w_load_f;
                end
            end
            if (i_cmd.lam_mul) begin
                r_round_max <= 7'd0;
            end
            if (i_cmd.decide) begin
                r_target <= w_new_tgt;
                r_pmult  <= w_new_pm;
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_kind;
            r_last <= i_in_last;
            r_cpu  <= i_in_data[1:0];
            r_idle <= i_in_data[33:2];
            r_wall <= i_in_data[97:66];
            r_cur  <= i_in_data[151:130];
            r_lo   <= i_in_data[173:152];
            r_hi   <= i_in_data[195:174];
        end
        if (i_cmd.delta) begin
            r_di    <= r_idle - r_prev_idle[w_idx];
            r_dw    <= r_wall - r_prev_wall[w_idx];
            r_pload <= r_prev_load[w_idx];
        end
        if (i_cmd.mul_load) begin
            r_rem   <= w_load_prod;
            r_dsh   <= {r_dw, 6'd0};
            r_q     <= 23'd0;
            r_recip <= 1'b0;
        end else if (i_cmd.lam_mul) begin
            r_rem     <= 39'(w_lam_prod);
            r_dsh     <= 38'({r_hi, 6'd0});
            r_q       <= 23'd0;
            r_recip   <= 1'b0;
            r_ml      <= r_round_max;
            r_lam_sat <= (w_lam_prod >= {r_hi, 7'd0});
        end else if (i_cmd.step_mul) begin
            r_rem   <= 39'(w_step_prod);
            r_q     <= 23'd0;
            r_recip <= 1'b1;
        end else if (i_cmd.div_step) begin
            if (r_recip) begin
                r_q <= w_recip_prod[54:32];
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - {1'b0, r_dsh};
                end
                r_q   <= {r_q[21:0], w_ge};
                r_dsh <= {1'b0, r_dsh[37:1]};
            end
        end
        if (i_cmd.lam_latch) begin
            if (r_hi == 22'd0) begin
                r_lam <= 7'd0;
            end else if (r_lam_sat || r_q[6:0] > 7'd100) begin
                r_lam <= 7'd100;
            end else begin
                r_lam <= r_q[6:0];
            end
        end
        if (i_cmd.decide) begin
            r_out_data <= {1'b0, r_lam, r_ml, w_new_pm, w_set, w_new_tgt};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/load_driven_frequency_stepper.sv =====
// load driven frequency stepper: per-cpu load from idle/wall samples, stepped target
// pacing: one item at a time, a round-closing sample also runs the second division
// and any step scaling; a held result stalls the input; two 7-step divisions set the pace
// reset (synchronous, active low) clears counters, loads, target, config to defaults
// depends on lds_pkg, lds_ctrl, lds_dp
module load_driven_frequency_stepper #(
    parameter int unsigned CPUS = lds_pkg::CPUS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input items
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cpu[1:0] idle_total[65:2] wall_total[129:66] cur_freq[151:130]
    // min_freq[173:152] max_freq[195:174], zero fill above
    input  logic [lds_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      s_axis_tlast,   // last_cpu
    input  logic                      s_axis_tuser,   // kind
    // result items
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // req_khz[21:0] set_freq[22] period_mul[32:23] peak_load[39:33]
    // load_at_max[46:40], zero fill above
    output logic [lds_pkg::OUT_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import lds_pkg::*;

    t_cmd    w_cmd;
    t_status w_stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    lds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // counters, divider, decision and output register
    lds_dp #(
        .CPUS (CPUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // at most one datapath command per cycle
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    // a result is only written when the output register can take it
    a_decide_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.decide |-> w_stat.out_free)
        else $error("result written over a pending item");

    // multiplier never reads as zero
    a_mult_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:23] != 10'd0))
        else $error("rate multiplier zero");

    // load figures stay within percent range
    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:33] <= 7'd100 && m_axis_tdata[46:40] <= 7'd100))
        else $error("load percent out of range");

endmodule
